// File: rtl/rlsa_pkg.sv
// Package for the recursive least-squares ARMAX unit: sizes, payload words,
// controller/datapath command and status types, Q16.16 helpers.
// No dependencies.
`timescale 1ns / 1ps
package rlsa_pkg;

	localparam int POLE_ORDER_DEF  = 2;
	localparam int ZERO_ORDER_DEF  = 2;
	localparam int NOISE_ORDER_DEF = 2;
	localparam int MAX_COEF        = 12;
	localparam int CIDX_W          = 4;

	localparam int REG_INIT_DIAG   = 0;
	localparam int REG_FORGET      = 1;
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 32;
	localparam logic [30:0] INIT_DIAG_RST = 31'd65536;
	localparam logic [16:0] FORGET_RST    = 17'd65536;
	localparam logic [16:0] LAM_MIN       = 17'd32768;
	localparam logic [16:0] LAM_MAX       = 17'd65536;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	typedef struct packed {
		logic               restart;
		logic signed [31:0] ctrl_in;
		logic signed [31:0] meas_out;
	} in_word_t;

	typedef struct packed {
		logic [CIDX_W-1:0]  coef_index;
		logic signed [31:0] coef_value;
		logic signed [31:0] pred_error;
		logic               last;
	} out_word_t;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE   = 4'd0,
		OP_LOAD   = 4'd1,  // restart/shift, capture input
		OP_FILL   = 4'd2,  // write scaled-identity element P(a,b)
		OP_ERR    = 4'd3,  // e accumulation, index a
		OP_ROW    = 4'd4,  // row[b] accumulation with P(a,b)
		OP_DEN    = 4'd5,  // s accumulation, index a
		OP_DIV1   = 4'd6,  // start outer/s divide for element (a,b)
		OP_DIV2   = 4'd7,  // start diff*2^16/lambda divide
		OP_PWR    = 4'd8,  // write back P(a,b)
		OP_GAIN   = 4'd9,  // gain accumulation with P(a,b)
		OP_COEF   = 4'd10, // theta[a] update
		OP_FIN    = 4'd11  // commit past values
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CIDX_W-1:0] a;
		logic [CIDX_W-1:0] b;
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
	} dp_sts_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return S32_MAX;
		if (v < -64'sd2147483648) return S32_MIN;
		return v[31:0];
	endfunction

	// Rounded Q16.16 product (floor of (p + 2^15) / 2^16), kept wide
	function automatic logic signed [48:0] qround(input logic signed [63:0] p);
		logic signed [63:0] t;
		t = p + 64'sd32768;
		return 49'(t >>> 16);
	endfunction

endpackage

// File: rtl/rlsa_div.sv
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// No dependencies.
`timescale 1ns / 1ps
module rlsa_div #(
	parameter int NW = 64,
	parameter int DW = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [NW-1:0] num,
	input  logic signed [DW-1:0] den,
	output logic                 busy,
	output logic signed [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] q_q;
	logic [DW:0]   r_q;
	logic [DW-1:0] d_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   trial;
	logic [DW:0]   rsh;

	// One shift-subtract step
	assign rsh   = {r_q[DW-1:0], q_q[NW-1]};
	assign trial = rsh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy  <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy  <= 1'b1;
			cnt_q <= CW'(NW);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) busy <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num[NW-1] ? -num : num;
			d_q   <= den[DW-1] ? -den : den;
			r_q   <= '0;
			neg_q <= num[NW-1] ^ den[DW-1];
		end else if (busy) begin
			if (!trial[DW]) begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= rsh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule

// File: rtl/rlsa_datapath.sv
// Datapath: regressor, coefficient and covariance storage, one shared
// 32x32 multiplier with accumulator, and a serial divider.
// Depends on rlsa_pkg, rlsa_div.
`timescale 1ns / 1ps
module rlsa_datapath #(
	parameter int NP = rlsa_pkg::POLE_ORDER_DEF,
	parameter int NZ = rlsa_pkg::ZERO_ORDER_DEF,
	parameter int NE = rlsa_pkg::NOISE_ORDER_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rlsa_pkg::dp_cmd_t    cmd,
	output rlsa_pkg::dp_sts_t    sts,
	input  rlsa_pkg::in_word_t   in_word,
	input  logic [30:0]          init_diag,
	input  logic [16:0]          forget_factor,
	output logic signed [31:0]   coef_rd,
	output logic signed [31:0]   err_rd
);
	localparam int N  = NP + NZ + NE;
	localparam int NN = N * N;
	localparam int PW = $clog2(NN);
	localparam int AW = $clog2(N);

	logic signed [31:0] phi_q   [N];
	logic signed [31:0] theta_q [N];
	logic signed [31:0] row_q   [N];
	logic signed [31:0] pmem    [NN];
	logic signed [31:0] y_q, u_q, e_q, s_q, g_q;
	logic signed [31:0] pno_q, pu_q, pe_q;
	logic [16:0]        lam_q;
	logic [30:0]        fill_diag_q;
	logic signed [52:0] acc_q;
	logic signed [52:0] acc_nx;
	logic signed [31:0] acc_sat;
	logic signed [31:0] s_sum;
	logic [AW-1:0]      ia, ib;
	logic [PW-1:0]      p_addr;
	logic signed [31:0] p_rd_q;
	logic               div_start;
	logic               div_busy;
	logic signed [63:0] div_num;
	logic signed [31:0] div_den;
	logic signed [63:0] div_quo;
	logic signed [32:0] diff;
	logic signed [31:0] ma, mb;
	logic signed [63:0] prod;
	logic signed [48:0] prod_r;

	rlsa_div #(.NW(64), .DW(32)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .busy(div_busy), .quo(div_quo)
	);

	assign sts.div_busy = div_busy;
	assign ia     = cmd.a[AW-1:0];
	assign ib     = cmd.b[AW-1:0];
	assign p_addr = PW'(cmd.a * N + cmd.b);

	// Shared multiplier operand select. P stays symmetric, so col equals row.
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			rlsa_pkg::OP_ERR: begin
				ma = phi_q[ia];
				mb = theta_q[ia];
			end
			rlsa_pkg::OP_ROW: begin
				ma = p_rd_q;
				mb = phi_q[ia];
			end
			rlsa_pkg::OP_DEN: begin
				ma = row_q[ia];
				mb = phi_q[ia];
			end
			rlsa_pkg::OP_DIV1: begin
				ma = row_q[ia];
				mb = row_q[ib];
			end
			rlsa_pkg::OP_GAIN: begin
				ma = p_rd_q;
				mb = phi_q[ib];
			end
			rlsa_pkg::OP_COEF: begin
				ma = g_q;
				mb = e_q;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end
	assign prod    = 64'(ma) * 64'(mb);
	assign prod_r  = rlsa_pkg::qround(prod);
	assign acc_nx  = acc_q + 53'(prod_r);
	assign acc_sat = rlsa_pkg::sat32(64'(acc_nx));
	assign s_sum   = rlsa_pkg::sat32(64'($signed({1'b0, lam_q})) + 64'(acc_sat));

	// Divider operands: outer/s first, then (P - q) * 2^16 / lambda
	assign diff      = 33'(p_rd_q) - 33'(rlsa_pkg::sat32(div_quo));
	assign div_start = (cmd.op == rlsa_pkg::OP_DIV1) || (cmd.op == rlsa_pkg::OP_DIV2);
	always_comb begin
		if (cmd.op == rlsa_pkg::OP_DIV1) begin
			div_num = prod;
			div_den = s_q;
		end else begin
			div_num = {{15{diff[32]}}, diff, 16'd0};
			div_den = {15'd0, lam_q};
		end
	end

	// Covariance memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.op == rlsa_pkg::OP_FILL)
			pmem[p_addr] <= (cmd.a == cmd.b) ? {1'b0, fill_diag_q} : '0;
		else if (cmd.op == rlsa_pkg::OP_PWR)
			pmem[p_addr] <= rlsa_pkg::sat32(div_quo);
		p_rd_q <= pmem[p_addr];
	end

	// Estimation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_diag_q <= rlsa_pkg::INIT_DIAG_RST;
			for (int i = 0; i < N; i++) begin
				phi_q[i]   <= '0;
				theta_q[i] <= '0;
			end
			pno_q <= '0;
			pu_q  <= '0;
			pe_q  <= '0;
		end else begin
			case (cmd.op)
				rlsa_pkg::OP_LOAD: begin
					if (in_word.restart) begin
						fill_diag_q <= init_diag;
						for (int i = 0; i < N; i++) begin
							phi_q[i]   <= '0;
							theta_q[i] <= '0;
						end
						pno_q <= '0;
						pu_q  <= '0;
						pe_q  <= '0;
					end else begin
						for (int i = 1; i < NP; i++) phi_q[i] <= phi_q[i-1];
						for (int i = 1; i < NZ; i++) phi_q[NP+i] <= phi_q[NP+i-1];
						for (int i = 1; i < NE; i++) phi_q[NP+NZ+i] <= phi_q[NP+NZ+i-1];
						phi_q[0]     <= pno_q;
						phi_q[NP]    <= pu_q;
						phi_q[NP+NZ] <= pe_q;
					end
				end
				rlsa_pkg::OP_COEF:
					theta_q[ia] <= rlsa_pkg::sat32(64'(theta_q[ia]) + 64'(prod_r));
				rlsa_pkg::OP_FIN: begin
					pe_q  <= e_q;
					pu_q  <= u_q;
					pno_q <= rlsa_pkg::sat32(-64'(y_q));
				end
				default: ;
			endcase
		end
	end

	// Accumulator and scalar registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			rlsa_pkg::OP_LOAD: begin
				y_q   <= in_word.meas_out;
				u_q   <= in_word.ctrl_in;
				acc_q <= '0;
				if (forget_factor < rlsa_pkg::LAM_MIN) lam_q <= rlsa_pkg::LAM_MIN;
				else if (forget_factor > rlsa_pkg::LAM_MAX) lam_q <= rlsa_pkg::LAM_MAX;
				else lam_q <= forget_factor;
			end
			rlsa_pkg::OP_ERR: begin
				if (ia == AW'(N - 1)) begin
					e_q   <= rlsa_pkg::sat32(64'(y_q) - 64'(acc_sat));
					acc_q <= '0;
				end else acc_q <= acc_nx;
			end
			rlsa_pkg::OP_ROW: begin
				if (ia == AW'(N - 1)) begin
					row_q[ib] <= acc_sat;
					acc_q     <= '0;
				end else acc_q <= acc_nx;
			end
			rlsa_pkg::OP_DEN: begin
				if (ia == AW'(N - 1)) begin
					s_q   <= (s_sum < 32'sd1) ? 32'sd1 : s_sum;
					acc_q <= '0;
				end else acc_q <= acc_nx;
			end
			rlsa_pkg::OP_GAIN: begin
				if (ib == AW'(N - 1)) begin
					g_q   <= acc_sat;
					acc_q <= '0;
				end else acc_q <= acc_nx;
			end
			default: ;
		endcase
	end

	assign coef_rd = theta_q[ia];
	assign err_rd  = e_q;
endmodule

// File: rtl/rlsa_ctrl.sv
// Controller: sequences one update through the datapath and emits results.
// Depends on rlsa_pkg.
`timescale 1ns / 1ps
module rlsa_ctrl #(
	parameter int N = rlsa_pkg::POLE_ORDER_DEF + rlsa_pkg::ZERO_ORDER_DEF +
		rlsa_pkg::NOISE_ORDER_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              restart,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output rlsa_pkg::dp_cmd_t cmd,
	input  rlsa_pkg::dp_sts_t sts
);
	localparam int IW = rlsa_pkg::CIDX_W;

	typedef enum logic [9:0] {
		S_BOOT = 10'b0000000001,
		S_IDLE = 10'b0000000010,
		S_FILL = 10'b0000000100,
		S_ERR  = 10'b0000001000,
		S_ROW  = 10'b0000010000,
		S_DEN  = 10'b0000100000,
		S_UPD  = 10'b0001000000,
		S_GAIN = 10'b0010000000,
		S_COEF = 10'b0100000000,
		S_OUT  = 10'b1000000000
	} state_t;

	// Per-element covariance update steps
	typedef enum logic [2:0] {
		U_DIV1 = 3'b001,
		U_DIV2 = 3'b010,
		U_PWR  = 3'b100
	} upd_t;

	state_t        st_q;
	upd_t          up_q;
	logic [IW-1:0] a_q, b_q;
	logic          ph_q;
	logic          a_end, b_end;

	assign a_end     = (a_q == IW'(N - 1));
	assign b_end     = (b_q == IW'(N - 1));
	assign in_ready  = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);

	// Command decode; MAC passes over P alternate a read phase and a use phase
	always_comb begin
		cmd.a  = a_q;
		cmd.b  = b_q;
		cmd.op = rlsa_pkg::OP_NONE;
		case (st_q)
			S_BOOT, S_FILL: cmd.op = rlsa_pkg::OP_FILL;
			S_IDLE: if (in_valid) cmd.op = rlsa_pkg::OP_LOAD;
			S_ERR:  cmd.op = rlsa_pkg::OP_ERR;
			S_ROW:  if (ph_q) cmd.op = rlsa_pkg::OP_ROW;
			S_DEN:  cmd.op = rlsa_pkg::OP_DEN;
			S_UPD: begin
				case (up_q)
					U_DIV1: cmd.op = rlsa_pkg::OP_DIV1;
					U_DIV2: if (!sts.div_busy) cmd.op = rlsa_pkg::OP_DIV2;
					U_PWR:  if (!sts.div_busy) cmd.op = rlsa_pkg::OP_PWR;
					default: cmd.op = rlsa_pkg::OP_NONE;
				endcase
			end
			S_GAIN: if (ph_q) cmd.op = rlsa_pkg::OP_GAIN;
			S_COEF: cmd.op = rlsa_pkg::OP_COEF;
			S_OUT:  if (out_ready && a_end) cmd.op = rlsa_pkg::OP_FIN;
			default: cmd.op = rlsa_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_BOOT;
			up_q <= U_DIV1;
			a_q  <= '0;
			b_q  <= '0;
			ph_q <= 1'b0;
		end else begin
			case (st_q)
				S_BOOT, S_FILL: begin
					b_q <= b_end ? '0 : b_q + 1'b1;
					if (b_end) begin
						a_q <= a_end ? '0 : a_q + 1'b1;
						if (a_end) st_q <= (st_q == S_BOOT) ? S_IDLE : S_ERR;
					end
				end
				S_IDLE: if (in_valid) begin
					st_q <= restart ? S_FILL : S_ERR;
					a_q  <= '0;
					b_q  <= '0;
				end
				S_ERR: begin
					a_q <= a_end ? '0 : a_q + 1'b1;
					if (a_end) st_q <= S_ROW;
				end
				S_ROW: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						a_q <= a_end ? '0 : a_q + 1'b1;
						if (a_end) begin
							b_q <= b_end ? '0 : b_q + 1'b1;
							if (b_end) st_q <= S_DEN;
						end
					end
				end
				S_DEN: begin
					a_q <= a_end ? '0 : a_q + 1'b1;
					if (a_end) begin
						st_q <= S_UPD;
						up_q <= U_DIV1;
					end
				end
				S_UPD: begin
					case (up_q)
						U_DIV1: up_q <= U_DIV2;
						U_DIV2: if (!sts.div_busy) up_q <= U_PWR;
						U_PWR: if (!sts.div_busy) begin
							up_q <= U_DIV1;
							b_q  <= b_end ? '0 : b_q + 1'b1;
							if (b_end) begin
								a_q <= a_end ? '0 : a_q + 1'b1;
								if (a_end) st_q <= S_GAIN;
							end
						end
						default: up_q <= U_DIV1;
					endcase
				end
				S_GAIN: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						b_q <= b_end ? '0 : b_q + 1'b1;
						if (b_end) st_q <= S_COEF;
					end
				end
				S_COEF: begin
					a_q  <= a_end ? '0 : a_q + 1'b1;
					st_q <= a_end ? S_OUT : S_GAIN;
				end
				S_OUT: if (out_ready) begin
					a_q <= a_end ? '0 : a_q + 1'b1;
					if (a_end) st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: rtl/recursive_least_squares_armax_unit.sv
// Recursive least-squares ARMAX estimator, Q16.16 with saturation. One input
// word is taken while the unit is idle; it runs a sequenced pass over a single
// shared multiplier and a one-bit-per-cycle 64-bit divider, then emits N result
// words, one per coefficient, the last one flagged. After reset the covariance
// is loaded before the first word is taken; a restart word reloads it first. An
// update makes two divides per covariance element, and its run time is set
// almost entirely by the divider; output stalls lengthen it further.
// Depends on rlsa_pkg, rlsa_ctrl, rlsa_datapath.
`timescale 1ns / 1ps
module recursive_least_squares_armax_unit #(
	parameter int POLE_ORDER  = rlsa_pkg::POLE_ORDER_DEF,
	parameter int ZERO_ORDER  = rlsa_pkg::ZERO_ORDER_DEF,
	parameter int NOISE_ORDER = rlsa_pkg::NOISE_ORDER_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  rlsa_pkg::in_word_t                in_word,
	output logic                              out_valid,
	input  logic                              out_ready,
	output rlsa_pkg::out_word_t               out_word,
	input  logic                              cfg_we,
	input  logic [rlsa_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [rlsa_pkg::CFG_DATA_W-1:0]   cfg_data
);
	localparam int N  = POLE_ORDER + ZERO_ORDER + NOISE_ORDER;
	localparam int IW = rlsa_pkg::CIDX_W;

	logic [30:0]        init_diag_q;
	logic [16:0]        forget_q;
	rlsa_pkg::dp_cmd_t  cmd;
	rlsa_pkg::dp_sts_t  sts;
	logic signed [31:0] coef_rd, err_rd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_diag_q <= rlsa_pkg::INIT_DIAG_RST;
			forget_q    <= rlsa_pkg::FORGET_RST;
		end else if (cfg_we) begin
			if (cfg_idx == rlsa_pkg::CFG_IDX_W'(rlsa_pkg::REG_INIT_DIAG))
				init_diag_q <= cfg_data[30:0];
			else if (cfg_idx == rlsa_pkg::CFG_IDX_W'(rlsa_pkg::REG_FORGET))
				forget_q <= cfg_data[16:0];
		end
	end

	rlsa_ctrl #(.N(N)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .restart(in_word.restart),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	rlsa_datapath #(.NP(POLE_ORDER), .NZ(ZERO_ORDER), .NE(NOISE_ORDER)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .in_word(in_word),
		.init_diag(init_diag_q), .forget_factor(forget_q),
		.coef_rd(coef_rd), .err_rd(err_rd)
	);

	assign out_word.coef_index = cmd.a;
	assign out_word.coef_value = coef_rd;
	assign out_word.pred_error = err_rd;
	assign out_word.last       = (cmd.a == IW'(N - 1));
endmodule

// File: rtl/rlsa_checker.sv
// Port-level checker for the RLS ARMAX unit, bound to the top level.
// Depends on rlsa_pkg.
`timescale 1ns / 1ps
module rlsa_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input rlsa_pkg::out_word_t out_word
);
	// No new word is taken while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("input ready while results pending");

	// An accepted input word closes the input until its update is done
	a_in_close: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input ready right after an accepted word");

	// Results are numbered in order
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !out_word.last) |=> (out_valid &&
		out_word.coef_index == $past(out_word.coef_index) + 1'b1))
		else $error("coefficient index skipped");

	// A held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_word))
		else $error("result changed while stalled");
endmodule

bind recursive_least_squares_armax_unit rlsa_checker u_rlsa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);
